### rtl/swhf_pkg.sv
// ----------------------------------------------------------------------------
// swhf_pkg
// Shared constants, request codes and controller/datapath interface types
// for the seed word hit finder.
// ----------------------------------------------------------------------------
package swhf_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned MaxWord    = 16;
  localparam int unsigned MaxSeqLen  = 65536;

  localparam int unsigned PatAw    = $clog2(MaxPattern);
  localparam int unsigned PatCntW  = $clog2(MaxPattern + 1);
  localparam int unsigned WinIdxW  = $clog2(MaxWord);
  localparam int unsigned FillW    = $clog2(MaxWord + 1);
  localparam int unsigned WordLenW = 5;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned SeqIdW   = 16;
  localparam int unsigned PosW     = 16;
  localparam int unsigned TotalW   = 32;

  localparam logic [WordLenW-1:0] WordLenReset = 5'd11;

  typedef enum logic [ReqW-1:0] {
    ReqClear  = 2'd0,
    ReqAppend = 2'd1,
    ReqData   = 2'd2
  } req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start;
    logic scan;
    logic flush;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic flush_done;
    logic hold_vld;
  } sts_t;

endpackage

### rtl/swhf_ctrl.sv
// ----------------------------------------------------------------------------
// swhf_ctrl
// Sequencer that accepts items and steps the datapath through the pattern
// scan and the final hit flush.
// ----------------------------------------------------------------------------
module swhf_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [swhf_pkg::ReqW-1:0]  req_type_i,
  input  swhf_pkg::sts_t             sts_i,
  output swhf_pkg::cmd_t             cmd_o,
  output logic                       in_stall_o
);
  import swhf_pkg::*;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StScan  = 3'b010,
    StFlush = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   start;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i & (state_q == StIdle);
  assign start      = accept & (req_type_i == ReqData);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = StScan;
      end
      StScan: begin
        if (sts_i.scan_done) state_d = StFlush;
      end
      StFlush: begin
        if (sts_i.flush_done) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.start  = start;
  assign cmd_o.scan   = (state_q == StScan);
  assign cmd_o.flush  = (state_q == StFlush);
  assign cmd_o.finish = (state_q == StFlush) & sts_i.flush_done;

endmodule

### rtl/swhf_dpath.sv
// ----------------------------------------------------------------------------
// swhf_dpath
// Pattern memory, character window, candidate wavefront, hit counter, hold
// stage and output register of the seed word hit finder.
// ----------------------------------------------------------------------------
module swhf_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swhf_pkg::cmd_t                 cmd_i,
  output swhf_pkg::sts_t                 sts_o,
  input  logic [swhf_pkg::ReqW-1:0]      req_type_i,
  input  logic [swhf_pkg::CharW-1:0]     char_code_i,
  input  logic [swhf_pkg::SeqIdW-1:0]    seq_id_i,
  input  logic                           seq_last_i,
  input  logic                           cfg_we_i,
  input  logic [swhf_pkg::WordLenW-1:0]  cfg_wdata_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [swhf_pkg::SeqIdW-1:0]    hit_seq_id_o,
  output logic [swhf_pkg::PosW-1:0]      hit_seq_start_o,
  output logic [swhf_pkg::PosW-1:0]      hit_seq_end_o,
  output logic [swhf_pkg::PatAw-1:0]     hit_pat_start_o,
  output logic [swhf_pkg::PatAw-1:0]     hit_pat_end_o,
  output logic [swhf_pkg::TotalW-1:0]    hit_total_o,
  output logic                           last_of_run_o
);
  import swhf_pkg::*;

  localparam logic [PosW-1:0] PosMax = PosW'(MaxSeqLen - 1);

  // Configuration and effective word length minus one.
  logic [WordLenW-1:0] wlen_q;
  logic [WinIdxW-1:0]  wm1_eff, wm1_q;
  logic [FillW-1:0]    wlen_eff;

  // Pattern memory.
  logic [CharW-1:0]    pat_mem [MaxPattern];
  logic [PatCntW-1:0]  pat_cnt_q;
  logic [CharW-1:0]    rd_data_q;
  logic                rd_vld_q;
  logic [PatAw-1:0]    rd_p_q;
  logic [PatCntW-1:0]  iss_q;

  // Window and sequence position.
  logic [CharW-1:0]    win_q [MaxWord];
  logic [FillW-1:0]    fill_q, fill_new;
  logic [PosW-1:0]     pos_q;

  // Item context latched at the start of a scan.
  logic                run_en_q, run_en_d;
  logic [SeqIdW-1:0]   cur_id_q;
  logic                cur_last_q;
  logic [PosW-1:0]     cur_pos_q, cur_start_q;

  // Candidate wavefront and hits.
  logic [MaxWord-1:0]  cand_q, cand_d, eq, wsel, wmask;
  logic                hit;
  logic [PatAw-1:0]    hit_s;
  logic [TotalW-1:0]   cnt_q, cnt_nxt;

  logic                hold_vld_q;
  logic [PatAw-1:0]    hold_s_q, hold_e_q;
  logic [TotalW-1:0]   hold_tot_q;

  logic                out_vld_q;
  logic                last_q;
  logic [SeqIdW-1:0]   o_id_q;
  logic [PosW-1:0]     o_start_q, o_end_q;
  logic [PatAw-1:0]    o_ps_q, o_pe_q;
  logic [TotalW-1:0]   o_tot_q;

  logic clear_req, append, end_clear;
  logic advance, issue_pend, issue, cmp;
  logic load_mid, load_last;

  always_comb begin
    if (wlen_q == '0) begin
      wm1_eff = '0;
    end else if (wlen_q > WordLenW'(MaxWord)) begin
      wm1_eff = WinIdxW'(MaxWord - 1);
    end else begin
      wm1_eff = WinIdxW'(wlen_q - WordLenW'(1));
    end
  end
  assign wlen_eff = FillW'(wm1_eff) + FillW'(1);

  assign clear_req = cmd_i.accept & (req_type_i == ReqClear);
  assign append    = cmd_i.accept & (req_type_i == ReqAppend) &
                     (pat_cnt_q < PatCntW'(MaxPattern));
  assign end_clear = cmd_i.finish & cur_last_q;

  assign fill_new = (fill_q < FillW'(MaxWord)) ? fill_q + FillW'(1) : fill_q;
  assign run_en_d = (fill_new >= wlen_eff) &
                    (pat_cnt_q >= PatCntW'(wlen_eff)) &
                    (pos_q != PosMax) &
                    (pos_q >= PosW'(wm1_eff));

  // The scan only moves when the output register can take a new hit.
  assign advance    = ~out_vld_q | ~out_stall_i;
  assign issue_pend = run_en_q & (iss_q < pat_cnt_q);
  assign issue      = cmd_i.scan & advance & issue_pend;
  assign cmp        = cmd_i.scan & advance & rd_vld_q;

  // A candidate word enters at window index wm1 and steps down one index per
  // pattern character; reaching index zero means all characters matched.
  always_comb begin
    for (int i = 0; i < MaxWord; i++) begin
      eq[i]    = (rd_data_q == win_q[i]);
      wsel[i]  = (WinIdxW'(i) == wm1_q);
      wmask[i] = (WinIdxW'(i) <= wm1_q);
    end
    cand_d = (({1'b0, cand_q[MaxWord-1:1]}) | wsel) & eq & wmask;
  end
  assign hit     = cand_d[0];
  assign hit_s   = rd_p_q - PatAw'(wm1_q);
  assign cnt_nxt = (cnt_q == '1) ? cnt_q : cnt_q + TotalW'(1);

  assign load_mid  = cmp & hit & hold_vld_q;
  assign load_last = cmd_i.flush & advance & hold_vld_q;

  always_ff @(posedge clk_i) begin
    if (append) begin
      pat_mem[pat_cnt_q[PatAw-1:0]] <= char_code_i;
    end
    if (issue) begin
      rd_data_q <= pat_mem[iss_q[PatAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q     <= WordLenReset;
      pat_cnt_q  <= '0;
      fill_q     <= '0;
      pos_q      <= '0;
      run_en_q   <= 1'b0;
      rd_vld_q   <= 1'b0;
      iss_q      <= '0;
      cand_q     <= '0;
      cnt_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      cur_last_q <= 1'b0;
      for (int i = 0; i < MaxWord; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
      end

      if (clear_req) begin
        pat_cnt_q <= '0;
      end else if (append) begin
        pat_cnt_q <= pat_cnt_q + PatCntW'(1);
      end

      if (clear_req | end_clear) begin
        fill_q <= '0;
        pos_q  <= '0;
        for (int i = 0; i < MaxWord; i++) begin
          win_q[i] <= '0;
        end
      end else if (cmd_i.start) begin
        fill_q <= fill_new;
        if (pos_q != PosMax) pos_q <= pos_q + PosW'(1);
        win_q[0] <= char_code_i;
        for (int i = 1; i < MaxWord; i++) begin
          win_q[i] <= win_q[i-1];
        end
      end

      if (cmd_i.start) begin
        run_en_q   <= run_en_d;
        cur_last_q <= seq_last_i;
        iss_q      <= '0;
        cand_q     <= '0;
        rd_vld_q   <= 1'b0;
      end else begin
        if (cmd_i.scan & advance) rd_vld_q <= issue;
        if (issue) iss_q <= iss_q + PatCntW'(1);
        if (cmp) cand_q <= cand_d;
      end

      if (clear_req) begin
        cnt_q <= '0;
      end else if (cmp & hit) begin
        cnt_q <= cnt_nxt;
      end

      if (cmp & hit) begin
        hold_vld_q <= 1'b1;
      end else if (load_last) begin
        hold_vld_q <= 1'b0;
      end

      if (load_mid | load_last) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      wm1_q       <= wm1_eff;
      cur_id_q    <= seq_id_i;
      cur_pos_q   <= pos_q;
      cur_start_q <= pos_q - PosW'(wm1_eff);
    end
    if (issue) begin
      rd_p_q <= iss_q[PatAw-1:0];
    end
    if (cmp & hit) begin
      hold_s_q   <= hit_s;
      hold_e_q   <= rd_p_q;
      hold_tot_q <= cnt_nxt;
    end
    if (load_mid | load_last) begin
      o_id_q    <= cur_id_q;
      o_start_q <= cur_start_q;
      o_end_q   <= cur_pos_q;
      o_ps_q    <= hold_s_q;
      o_pe_q    <= hold_e_q;
      o_tot_q   <= hold_tot_q;
      last_q    <= load_last;
    end
  end

  assign sts_o.scan_done  = ~issue_pend & ~rd_vld_q;
  assign sts_o.flush_done = ~hold_vld_q | advance;
  assign sts_o.hold_vld   = hold_vld_q;

  assign out_valid_o     = out_vld_q;
  assign hit_seq_id_o    = o_id_q;
  assign hit_seq_start_o = o_start_q;
  assign hit_seq_end_o   = o_end_q;
  assign hit_pat_start_o = o_ps_q;
  assign hit_pat_end_o   = o_pe_q;
  assign hit_total_o     = o_tot_q;
  assign last_of_run_o   = last_q;

endmodule

### rtl/seed_word_hit_finder.sv
// ----------------------------------------------------------------------------
// seed_word_hit_finder
// Exact seed word hit finder: loads a query pattern, cuts it into every
// overlapping word of the configured length and reports each occurrence of
// any of those words in a stream of database characters.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake                | Payload
//   --------+-----------+--------------------------+-------------------------
//   in      | input     | in_valid_i / in_stall_o  | req_type, char, seq id
//   out     | output    | out_valid_o / out_stall_i| one hit per item
//   cfg     | input     | cfg_we_i                 | word length (5 bits)
//
// A clear or pattern append item leaves the controller idle. A database
// character steps it from idle through the scan and flush states back to
// idle; the scan reads the pattern memory through its single read port,
// one character per cycle unless the output stalls.
// A stalled output register freezes the scan until the pending hit is taken.
// Reset is asynchronous and active low; the pattern memory is not cleared, as
// only entries below the pattern count are ever read.
//
// The scan walks the pattern in ascending order. Each pattern character is
// compared against all window characters at once, and a wavefront of
// candidate words, one bit per window index, carries partial matches forward.
// A completed word is parked in a hold stage so the last hit of a character
// can be flagged once the scan is over.
// ----------------------------------------------------------------------------
module seed_word_hit_finder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [swhf_pkg::ReqW-1:0]      req_type_i,
  input  logic [swhf_pkg::CharW-1:0]     char_code_i,
  input  logic [swhf_pkg::SeqIdW-1:0]    seq_id_i,
  input  logic                           seq_last_i,
  input  logic                           cfg_we_i,
  input  logic [swhf_pkg::WordLenW-1:0]  cfg_wdata_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [swhf_pkg::SeqIdW-1:0]    hit_seq_id_o,
  output logic [swhf_pkg::PosW-1:0]      hit_seq_start_o,
  output logic [swhf_pkg::PosW-1:0]      hit_seq_end_o,
  output logic [swhf_pkg::PatAw-1:0]     hit_pat_start_o,
  output logic [swhf_pkg::PatAw-1:0]     hit_pat_end_o,
  output logic [swhf_pkg::TotalW-1:0]    hit_total_o,
  output logic                           last_of_run_o
);
  import swhf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller owns the input handshake and sequences each item.
  swhf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath holds all storage and drives the output channel.
  swhf_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .seq_id_i        (seq_id_i),
    .seq_last_i      (seq_last_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .hit_seq_id_o    (hit_seq_id_o),
    .hit_seq_start_o (hit_seq_start_o),
    .hit_seq_end_o   (hit_seq_end_o),
    .hit_pat_start_o (hit_pat_start_o),
    .hit_pat_end_o   (hit_pat_end_o),
    .hit_total_o     (hit_total_o),
    .last_of_run_o   (last_of_run_o)
  );

  // A hit spans the same number of characters in the sequence and the pattern.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((hit_seq_end_o - hit_seq_start_o) ==
                     PosW'(hit_pat_end_o - hit_pat_start_o)))
    else $error("hit span differs between sequence and pattern");

  // No parked hit may remain once the block is ready for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !sts.hold_vld)
    else $error("hold stage still full while idle");

  // New hits are only produced while an item is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("hit produced while idle");

  // A flush is only finished when the hold stage is empty or drains now.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> !sts.hold_vld)
    else $error("hold stage not empty after flush");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the seed word hit finder. A directed table
// walks the corner cases, and random phases then load patterns under varied
// word lengths and stream sequences built partly from them. Every hit is
// checked field by field against an in-bench predictor of the finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import swhf_pkg::*;

  // Request code the block has no meaning for; it must be ignored.
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;

  // A database character scans at most the whole pattern, so this many idle
  // cycles cover any scan still running with no hit due.
  localparam int unsigned IdleCycles = MaxPattern + 16;
  localparam int unsigned RandItems  = 130;
  localparam int unsigned CycleLimit = 2_000_000;

  // One hit as it leaves the block.
  typedef struct packed {
    logic [SeqIdW-1:0] seq_id;
    logic [PosW-1:0]   seq_start;
    logic [PosW-1:0]   seq_end;
    logic [PatAw-1:0]  pat_start;
    logic [PatAw-1:0]  pat_end;
    logic [TotalW-1:0] total;
    logic              last_hit;
  } hit_t;

  // One row of the directed table. A row either writes the word length or
  // sends one item; a typed row carries its single expected hit.
  typedef struct packed {
    logic                is_cfg;
    logic [WordLenW-1:0] wl;
    logic [ReqW-1:0]     req;
    logic [CharW-1:0]    ch;
    logic [SeqIdW-1:0]   sid;
    logic                last;
    logic                typed;
    hit_t                hit;
  } dir_row_t;

  localparam hit_t NoHit = '0;

  // The directed table. It starts at the reset word length with an empty
  // pattern, then covers a word length of zero, the extreme character codes
  // and sequence ids, the end-of-sequence restart, an ignored request code,
  // a clear, overlapping hits within one pattern, a sequence id change with
  // no end marker, and a word length above the maximum with a short pattern.
  localparam dir_row_t DirTable [23] = '{
    '{1'b0, 5'd0,  ReqData,   8'h41, 16'h0005, 1'b0, 1'b0, NoHit},
    '{1'b1, 5'd0,  ReqClear,  8'h00, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h00, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'hFF, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'hFF, 16'hFFFF, 1'b0, 1'b1,
      '{16'hFFFF, 16'd1, 16'd1, 6'd1, 6'd1, 32'd1, 1'b1}},
    '{1'b0, 5'd0,  ReqData,   8'h00, 16'h0000, 1'b1, 1'b1,
      '{16'h0000, 16'd2, 16'd2, 6'd0, 6'd0, 32'd2, 1'b1}},
    '{1'b0, 5'd0,  ReqData,   8'h00, 16'h0007, 1'b0, 1'b1,
      '{16'h0007, 16'd0, 16'd0, 6'd0, 6'd0, 32'd3, 1'b1}},
    '{1'b0, 5'd0,  ReqUnused, 8'hFF, 16'hFFFF, 1'b1, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqClear,  8'h00, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h00, 16'h0007, 1'b0, 1'b0, NoHit},
    '{1'b1, 5'd3,  ReqClear,  8'h00, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h61, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h62, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h61, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h62, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqAppend, 8'h61, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h61, 16'h0064, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h62, 16'h0064, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h61, 16'h0064, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h62, 16'h00C8, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h61, 16'h00C8, 1'b1, 1'b0, NoHit},
    '{1'b1, 5'd31, ReqClear,  8'h00, 16'h0000, 1'b0, 1'b0, NoHit},
    '{1'b0, 5'd0,  ReqData,   8'h61, 16'h00C8, 1'b0, 1'b0, NoHit}
  };

  // Block ports. Every input has a known value from time zero.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ReqW-1:0]     req_type_i  = '0;
  logic [CharW-1:0]    char_code_i = '0;
  logic [SeqIdW-1:0]   seq_id_i    = '0;
  logic                seq_last_i  = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [WordLenW-1:0] cfg_wdata_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SeqIdW-1:0]   hit_seq_id_o;
  logic [PosW-1:0]     hit_seq_start_o;
  logic [PosW-1:0]     hit_seq_end_o;
  logic [PatAw-1:0]    hit_pat_start_o;
  logic [PatAw-1:0]    hit_pat_end_o;
  logic [TotalW-1:0]   hit_total_o;
  logic                last_of_run_o;

  // Predictor state: a private copy of the finder's register and memories.
  logic [WordLenW-1:0] word_len_q = WordLenReset;
  logic [CharW-1:0]    pat_mem [MaxPattern];
  int unsigned         pat_cnt    = 0;
  logic [CharW-1:0]    win_chars [MaxWord] = '{default: '0};
  int unsigned         win_fill   = 0;
  int unsigned         seq_pos    = 0;
  logic [TotalW-1:0]   hit_count  = '0;

  hit_t        pending_hits [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_run   = 0;
  // When set, the matching side runs with no idle cycles at all.
  bit          calm_in     = 1'b0;
  bit          calm_out    = 1'b0;

  seed_word_hit_finder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .char_code_i     (char_code_i),
    .seq_id_i        (seq_id_i),
    .seq_last_i      (seq_last_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_seq_id_o    (hit_seq_id_o),
    .hit_seq_start_o (hit_seq_start_o),
    .hit_seq_end_o   (hit_seq_end_o),
    .hit_pat_start_o (hit_pat_start_o),
    .hit_pat_end_o   (hit_pat_end_o),
    .hit_total_o     (hit_total_o),
    .last_of_run_o   (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // The word length in use: zero acts as one, anything above the window
  // size acts as the window size.
  function automatic int unsigned eff_word_len(input logic [WordLenW-1:0] v);
    if (v == 0) begin
      return 1;
    end
    if (v > MaxWord) begin
      return MaxWord;
    end
    return 32'(v);
  endfunction

  // Idle lengths: half of them zero, most of the rest short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void restart_window();
    win_chars = '{default: '0};
    win_fill  = 0;
    seq_pos   = 0;
  endfunction

  // Advances the predictor by one accepted item. For a database character
  // the window shifts, then every pattern word is compared in ascending
  // order of pattern start; matches become expected hits when keep is set.
  function automatic void step_finder_model(input logic [ReqW-1:0] req,
                                            input logic [CharW-1:0] ch,
                                            input logic [SeqIdW-1:0] sid,
                                            input logic last, input bit keep);
    int unsigned w, pos, i, s, k;
    bit          ok;
    hit_t        h;
    hit_t        found [$];
    if (req == ReqClear) begin
      pat_cnt   = 0;
      hit_count = '0;
      restart_window();
    end else if (req == ReqAppend) begin
      // Appends past a full pattern are dropped.
      if (pat_cnt < MaxPattern) begin
        pat_mem[pat_cnt] = ch;
        pat_cnt++;
      end
    end else if (req == ReqData) begin
      w   = eff_word_len(word_len_q);
      pos = seq_pos;
      for (i = MaxWord - 1; i > 0; i--) begin
        win_chars[i] = win_chars[i-1];
      end
      win_chars[0] = ch;
      if (win_fill < MaxWord) begin
        win_fill++;
      end
      // No hit while the window or the pattern is shorter than a word, and
      // none once the position has reached its saturated value.
      if (win_fill >= w && pat_cnt >= w && pos < MaxSeqLen - 1 && pos + 1 >= w) begin
        for (s = 0; s + w <= pat_cnt; s++) begin
          ok = 1'b1;
          for (k = 0; k < w; k++) begin
            if (pat_mem[s+k] != win_chars[w-1-k]) begin
              ok = 1'b0;
            end
          end
          if (ok) begin
            if (hit_count != '1) begin
              hit_count++;
            end
            h.seq_id    = sid;
            h.seq_start = PosW'(pos + 1 - w);
            h.seq_end   = PosW'(pos);
            h.pat_start = PatAw'(s);
            h.pat_end   = PatAw'(s + w - 1);
            h.total     = hit_count;
            h.last_hit  = 1'b0;
            found = {found, h};
          end
        end
        if (found.size() != 0) begin
          found[found.size()-1].last_hit = 1'b1;
        end
      end
      if (seq_pos < MaxSeqLen - 1) begin
        seq_pos++;
      end
      // The end marker restarts the window after this character's hits.
      if (last) begin
        restart_window();
      end
      if (keep) begin
        foreach (found[j]) begin
          pending_hits = {pending_hits, found[j]};
        end
      end
    end
  endfunction

  // Presents one item after a random gap and holds it until accepted. Valid
  // is only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input logic [ReqW-1:0] req, input logic [CharW-1:0] ch,
                           input logic [SeqIdW-1:0] sid, input logic last,
                           input bit keep);
    int unsigned gap;
    gap = calm_in ? 0 : gap_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    char_code_i <= ch;
    seq_id_i    <= sid;
    seq_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    step_finder_model(req, ch, sid, last, keep);
  endtask

  // Waits for every expected hit, then lets any scan with no hit finish.
  task automatic drain_hits();
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  // Word length writes happen only with the block idle.
  task automatic set_word_len(input logic [WordLenW-1:0] v);
    in_valid_i <= 1'b0;
    drain_hits();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    word_len_q = v;
  endtask

  // Output stall: bursts of random length, or none at all in calm stretches.
  always @(posedge clk_i) begin
    if (calm_out) begin
      out_stall_i <= 1'b0;
      stall_run   <= 0;
    end else if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run   <= stall_run - 1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(99) < 30) begin
        stall_run <= gap_len();
      end
    end
  end

  // Every accepted hit is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_hits
    hit_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected hit: seq_id %0h seq_end %0d pat_start %0d",
               hit_seq_id_o, hit_seq_end_o, hit_pat_start_o);
        fail_count++;
      end else begin
        want = pending_hits.pop_front();
        if (hit_seq_id_o !== want.seq_id) begin
          $error("hit_seq_id: expected %0h, got %0h", want.seq_id, hit_seq_id_o);
          fail_count++;
        end
        if (hit_seq_start_o !== want.seq_start) begin
          $error("hit_seq_start: expected %0d, got %0d", want.seq_start, hit_seq_start_o);
          fail_count++;
        end
        if (hit_seq_end_o !== want.seq_end) begin
          $error("hit_seq_end: expected %0d, got %0d", want.seq_end, hit_seq_end_o);
          fail_count++;
        end
        if (hit_pat_start_o !== want.pat_start) begin
          $error("hit_pat_start: expected %0d, got %0d", want.pat_start, hit_pat_start_o);
          fail_count++;
        end
        if (hit_pat_end_o !== want.pat_end) begin
          $error("hit_pat_end: expected %0d, got %0d", want.pat_end, hit_pat_end_o);
          fail_count++;
        end
        if (hit_total_o !== want.total) begin
          $error("hit_total: expected %0d, got %0d", want.total, hit_total_o);
          fail_count++;
        end
        if (last_of_run_o !== want.last_hit) begin
          $error("last_of_run: expected %0b, got %0b", want.last_hit, last_of_run_o);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned         phase, w, plen, len, s, k, r, nsym, rand_items;
    logic [CharW-1:0]    base, ch;
    logic [SeqIdW-1:0]   sid;
    logic [WordLenW-1:0] wl;
    bit                  full, end_last;
    logic [CharW-1:0]    pat_chars [$];
    logic [CharW-1:0]    seq_chars [$];

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Typed rows still advance the predictor, but their hit
    // comes from the table.
    foreach (DirTable[i]) begin
      if (DirTable[i].is_cfg) begin
        set_word_len(DirTable[i].wl);
      end else begin
        send_item(DirTable[i].req, DirTable[i].ch, DirTable[i].sid, DirTable[i].last,
                  !DirTable[i].typed);
        if (DirTable[i].typed) begin
          pending_hits = {pending_hits, DirTable[i].hit};
        end
      end
    end

    // Random phases. Each one picks a word length, clears, loads a pattern
    // over a small alphabet and streams sequences built partly from pattern
    // words, so most characters lead somewhere. The first phases pin the
    // maximum word length, a length of one with a full pattern of a single
    // character (every word hits), and a length beyond the maximum.
    rand_items = 0;
    phase      = 0;
    while (rand_items < RandItems) begin
      case (phase)
        0: begin
          wl = 5'd16;
        end
        1: begin
          wl = 5'd1;
        end
        2: begin
          wl = 5'd31;
        end
        default: begin
          case ($urandom_range(5))
            0: wl = 5'd0;
            1: wl = WordLenW'($urandom_range(1, 4));
            2: wl = 5'd16;
            3: wl = WordLenW'($urandom_range(17, 31));
            default: wl = WordLenW'($urandom_range(2, 15));
          endcase
        end
      endcase
      set_word_len(wl);
      w        = eff_word_len(wl);
      calm_in  = ($urandom_range(3) == 0);
      calm_out = ($urandom_range(3) == 0);
      full     = (phase == 1) || ($urandom_range(9) == 0);
      // A full pattern gets a few extra appends that must be dropped; a
      // short pattern cannot produce any word.
      if (full) begin
        plen = MaxPattern + $urandom_range(1, 3);
      end else if (phase > 2 && $urandom_range(5) == 0) begin
        plen = $urandom_range(0, w - 1);
      end else begin
        plen = $urandom_range(w, (w + 10 > MaxPattern) ? MaxPattern : w + 10);
      end
      base = CharW'($urandom);
      nsym = full ? 1 : $urandom_range(2, 3);

      send_item(ReqClear, CharW'($urandom), SeqIdW'($urandom), 1'($urandom), 1'b1);
      rand_items++;
      pat_chars.delete();
      repeat (plen) begin
        ch = base + CharW'($urandom_range(0, nsym - 1));
        send_item(ReqAppend, ch, SeqIdW'($urandom), 1'($urandom), 1'b1);
        if (pat_chars.size() < MaxPattern) begin
          pat_chars = {pat_chars, ch};
        end
        rand_items++;
      end

      repeat ($urandom_range(1, 2)) begin
        sid      = SeqIdW'($urandom);
        // Without the end marker the next sequence id continues the window.
        end_last = ($urandom_range(3) != 0);
        len      = $urandom_range(w, w + 8);
        seq_chars.delete();
        while (seq_chars.size() < len) begin
          if (pat_chars.size() >= w && $urandom_range(3) == 0) begin
            s = $urandom_range(0, pat_chars.size() - w);
            for (k = 0; k < w; k++) begin
              seq_chars = {seq_chars, pat_chars[s+k]};
            end
          end else if ($urandom_range(9) == 0) begin
            seq_chars = {seq_chars, CharW'($urandom)};
          end else begin
            seq_chars = {seq_chars, CharW'(base + CharW'($urandom_range(0, nsym - 1)))};
          end
        end
        foreach (seq_chars[i]) begin
          // Noise between characters: ignored requests, pattern growth and
          // the occasional clear in the middle of a sequence.
          r = $urandom_range(99);
          if (r < 4) begin
            send_item(ReqUnused, CharW'($urandom), SeqIdW'($urandom), 1'($urandom), 1'b1);
          end else if (r < 6) begin
            send_item(ReqAppend, base + CharW'($urandom_range(0, nsym - 1)),
                      SeqIdW'($urandom), 1'($urandom), 1'b1);
            rand_items++;
          end else if (r == 6) begin
            send_item(ReqClear, CharW'($urandom), SeqIdW'($urandom), 1'($urandom), 1'b1);
            rand_items++;
          end
          send_item(ReqData, seq_chars[i], sid,
                    end_last && (i == seq_chars.size() - 1), 1'b1);
          rand_items++;
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    drain_hits();
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
